[hw/rtl/acr_pkg.sv]
`default_nettype none
package acr_pkg;

    typedef logic [127:0] blk_t;

    localparam logic [127:0] DEFAULT_KEY = 128'hA4E375C6B09FD185F27C4E96FC273AE4;
    localparam logic [7:0]   CTRL_MASK   = 8'hBF;
    localparam int           NUM_ROUNDS  = 10;
    localparam logic [4:0]   LEN_SAT     = 5'd17;

    // Configuration register indexes
    localparam logic [2:0] REG_CUR_KEY_HI  = 3'd0;
    localparam logic [2:0] REG_CUR_KEY_LO  = 3'd1;
    localparam logic [2:0] REG_PREV_KEY_HI = 3'd2;
    localparam logic [2:0] REG_PREV_KEY_LO = 3'd3;
    localparam logic [2:0] REG_CUR_KEY_NUM = 3'd4;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    // Byte i of a block sits at bits 127-8i.
    function automatic logic [7:0] get_byte(input blk_t b, input int i);
        get_byte = b[127 - 8*i -: 8];
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] a);
        xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
    endfunction

    // One AES round: sub bytes, shift rows, optional mix columns, add round key.
    function automatic blk_t aes_round(input blk_t s, input blk_t rk, input logic last);
        logic [7:0] u [16];
        logic [7:0] a0, a1, a2, a3, al;
        blk_t o;
        for (int i = 0; i < 16; i++)
        begin
            u[i] = SBOX[get_byte(s, (i & 3) + 4 * (((i >> 2) + (i & 3)) & 3))];
        end
        if (!last)
        begin
            for (int c = 0; c < 4; c++)
            begin
                a0 = u[4*c]; a1 = u[4*c+1]; a2 = u[4*c+2]; a3 = u[4*c+3];
                al = a0 ^ a1 ^ a2 ^ a3;
                u[4*c]   = a0 ^ al ^ xt(a0 ^ a1);
                u[4*c+1] = a1 ^ al ^ xt(a1 ^ a2);
                u[4*c+2] = a2 ^ al ^ xt(a2 ^ a3);
                u[4*c+3] = a3 ^ al ^ xt(a3 ^ a0);
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            o[127 - 8*i -: 8] = u[i];
        end
        aes_round = o ^ rk;
    endfunction

    // Next round key from the previous one.
    function automatic blk_t key_step(input blk_t k, input logic [7:0] rc);
        logic [31:0] t, w0, w1, w2, w3;
        t  = {SBOX[k[23:16]] ^ rc, SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]};
        w0 = k[127:96] ^ t;
        w1 = k[95:64] ^ w0;
        w2 = k[63:32] ^ w1;
        w3 = k[31:0] ^ w2;
        key_step = {w0, w1, w2, w3};
    endfunction

    function automatic logic [7:0] rcon(input int r);
        logic [7:0] c;
        c = 8'h01;
        for (int i = 1; i < NUM_ROUNDS; i++)
        begin
            if (i < r)
            begin
                c = xt(c);
            end
        end
        rcon = c;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/acr_if.sv]
`default_nettype none
interface acr_req_if;
    logic        valid;
    logic        ready;
    logic [47:0] challenge;
    logic [7:0]  key_number;
    logic [47:0] nonce;
    logic [7:0]  msg_counter;
    logic [7:0]  control_byte;
    logic [7:0]  msg_type;
    logic [23:0] sender_addr;
    logic [23:0] dest_addr;
    logic [4:0]  payload_len;
    logic [7:0]  payload_first;
    logic [63:0] payload_mid;
    logic [63:0] payload_tail;
    modport source (output valid, challenge, key_number, nonce, msg_counter, control_byte,
                    msg_type, sender_addr, dest_addr, payload_len, payload_first,
                    payload_mid, payload_tail, input ready);
    modport sink (input valid, challenge, key_number, nonce, msg_counter, control_byte,
                  msg_type, sender_addr, dest_addr, payload_len, payload_first,
                  payload_mid, payload_tail, output ready);
endinterface

interface acr_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] response_hi;
    logic [63:0] response_lo;
    logic [31:0] ack_auth;
    logic        status;
    modport source (output valid, response_hi, response_lo, ack_auth, status, input ready);
    modport sink (input valid, response_hi, response_lo, ack_auth, status, output ready);
endinterface
`default_nettype wire

[hw/rtl/aes_challenge_response_gen_top.sv]
// AES-128 challenge-response generator.
// Input channel req (valid/ready): challenge, key index, nonce, frame header and
// payload bytes. Output channel rsp (valid/ready): 16-byte response, 4-byte ack
// authenticator and status (1 = no key for the requested index, data fields 0).
// Config: write enable cfg_we, index cfg_addr (0..4), data cfg_wdata; write only
// while the pipeline is empty.
// Structure: stage 0 registers the selected key and whitened block, then 20 round
// stages (10 rounds of the first encryption with key expansion running alongside,
// payload XOR and whitening folded into round 1 of the second encryption, then 9
// more rounds); the last round stage is the output register.
// Throughput: one item per cycle while rsp is not stalling; the whole pipe advances together.
// Stall: when rsp is held off, the pipe freezes (ready follows the output
// register's free state); nothing is dropped or repeated.
// Reset: all valid bits and key registers clear; first item accepted right after.
`default_nettype none
module aes_challenge_response_gen_top
    import acr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [63:0] cfg_wdata,
    acr_req_if.sink          req,
    acr_rsp_if.source        rsp
);

    localparam int NSTG = 2 * NUM_ROUNDS;

    logic [63:0] cur_hi_reg, cur_lo_reg, prev_hi_reg, prev_lo_reg;
    logic [7:0]  cur_num_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_hi_reg  <= '0;
            cur_lo_reg  <= '0;
            prev_hi_reg <= '0;
            prev_lo_reg <= '0;
            cur_num_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_CUR_KEY_HI:  cur_hi_reg  <= cfg_wdata;
                REG_CUR_KEY_LO:  cur_lo_reg  <= cfg_wdata;
                REG_PREV_KEY_HI: prev_hi_reg <= cfg_wdata;
                REG_PREV_KEY_LO: prev_lo_reg <= cfg_wdata;
                REG_CUR_KEY_NUM: cur_num_reg <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // Pipeline stages 0..NSTG: stage 0 holds selected key and initial state.
    logic        vld_reg  [NSTG+1];
    logic        nok_reg  [NSTG+1];
    blk_t        st_reg   [NSTG+1];
    blk_t        key_reg  [NSTG+1];
    blk_t        k0_reg   [NUM_ROUNDS+1];
    logic [4:0]  len_reg  [NUM_ROUNDS+1];
    logic [127:0] pay_reg [NUM_ROUNDS+1];
    logic [31:0] ack_reg  [NSTG+1];
    logic        adv;

    assign adv       = !vld_reg[NSTG] || rsp.ready;
    assign req.ready = adv;

    // Stage 0: key selection, challenge XOR and initial add round key
    blk_t       sel_key, blk_in;
    logic       no_key;
    logic [4:0] len_sat;
    always_comb
    begin
        no_key  = 1'b0;
        sel_key = DEFAULT_KEY;
        priority if (req.key_number == 8'd0)
            sel_key = DEFAULT_KEY;
        else if (req.key_number == cur_num_reg)
            sel_key = {cur_hi_reg, cur_lo_reg};
        else if (cur_num_reg != 8'd0 && req.key_number == cur_num_reg - 8'd1)
            sel_key = {prev_hi_reg, prev_lo_reg};
        else
            no_key = 1'b1;
        sel_key[127:80] = sel_key[127:80] ^ req.challenge;
        len_sat = (req.payload_len > LEN_SAT) ? LEN_SAT : req.payload_len;
        blk_in = {req.nonce, req.msg_counter, req.control_byte & CTRL_MASK, req.msg_type,
                  req.sender_addr, req.dest_addr,
                  (len_sat != 5'd0) ? req.payload_first : 8'h00};
    end

    // Mask of payload bytes XORed into the first ciphertext
    function automatic blk_t pay_mask(input blk_t p, input logic [4:0] len);
        blk_t m;
        for (int i = 0; i < 16; i++)
        begin
            m[127 - 8*i -: 8] = (5'(i + 1) < len) ? p[127 - 8*i -: 8] : 8'h00;
        end
        pay_mask = m;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= NSTG; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= req.valid;
            for (int s = 1; s <= NSTG; s++)
            begin
                vld_reg[s] <= vld_reg[s-1];
            end
        end
    end

    // Datapath: stages 1..10 first pass, stage 11 = second AddRoundKey+round 1, etc.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nok_reg[0] <= no_key;
            key_reg[0] <= sel_key;
            k0_reg[0]  <= sel_key;
            st_reg[0]  <= blk_in ^ sel_key;
            ack_reg[0] <= '0;
            len_reg[0] <= len_sat;
            pay_reg[0] <= {req.payload_mid, req.payload_tail};
            for (int s = 1; s <= NUM_ROUNDS; s++)
            begin
                nok_reg[s] <= nok_reg[s-1];
                key_reg[s] <= key_step(key_reg[s-1], rcon(s));
                k0_reg[s]  <= k0_reg[s-1];
                st_reg[s]  <= aes_round(st_reg[s-1], key_step(key_reg[s-1], rcon(s)),
                                        s == NUM_ROUNDS);
                ack_reg[s] <= '0;
                len_reg[s] <= len_reg[s-1];
                pay_reg[s] <= pay_reg[s-1];
            end
            // Stage 11: first ciphertext done; XOR payload, whitening, round 1
            nok_reg[NUM_ROUNDS+1] <= nok_reg[NUM_ROUNDS];
            ack_reg[NUM_ROUNDS+1] <= st_reg[NUM_ROUNDS][127:96];
            key_reg[NUM_ROUNDS+1] <= key_step(k0_reg[NUM_ROUNDS], rcon(1));
            st_reg[NUM_ROUNDS+1]  <= aes_round(st_reg[NUM_ROUNDS]
                                        ^ pay_mask(pay_reg[NUM_ROUNDS], len_reg[NUM_ROUNDS])
                                        ^ k0_reg[NUM_ROUNDS],
                                        key_step(k0_reg[NUM_ROUNDS], rcon(1)), 1'b0);
            for (int s = NUM_ROUNDS + 2; s <= NSTG; s++)
            begin
                nok_reg[s] <= nok_reg[s-1];
                ack_reg[s] <= ack_reg[s-1];
                key_reg[s] <= key_step(key_reg[s-1], rcon(s - NUM_ROUNDS));
                st_reg[s]  <= aes_round(st_reg[s-1],
                                        key_step(key_reg[s-1], rcon(s - NUM_ROUNDS)),
                                        s == NSTG);
            end
        end
    end

    // Output (last stage is the output register)
    assign rsp.valid       = vld_reg[NSTG];
    assign rsp.status      = nok_reg[NSTG];
    assign rsp.response_hi = nok_reg[NSTG] ? 64'd0 : st_reg[NSTG][127:64];
    assign rsp.response_lo = nok_reg[NSTG] ? 64'd0 : st_reg[NSTG][63:0];
    assign rsp.ack_auth    = nok_reg[NSTG] ? 32'd0 : ack_reg[NSTG];

`ifndef SYNTH
    // A held result must not change while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.response_hi))
        else $error("result changed under stall");
    // Input must be refused while output is stalled
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |-> !req.ready)
        else $error("input accepted during stall");
    // No-key result carries zero data
    a_nokey: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status |-> rsp.ack_auth == 32'd0)
        else $error("no-key result with data");
`endif

endmodule
`default_nettype wire

[dv/acr_checker.sv]
`timescale 1ns / 1ps
module acr_checker
    import acr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [63:0] cfg_wdata,
    acr_req_if          req,
    acr_rsp_if          rsp,
    output int          fail_count,
    output int          pending
);

    localparam logic [127:0] BUILTIN_KEY = 128'hA4E375C6B09FD185F27C4E96FC273AE4;

    typedef struct packed {
        logic [63:0] response_hi;
        logic [63:0] response_lo;
        logic [31:0] ack_auth;
        logic        status;
    } answer_t;

    logic [127:0] cur_key, prev_key;
    logic [7:0]   cur_num;
    answer_t      answers [$];

    // Forward S-box, generated from the field inverse and affine map
    logic [7:0] sub_tab [256];

    function automatic logic [7:0] dbl(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        logic [7:0] x;
        p = '0;
        x = a;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i]) p ^= x;
            x = dbl(x);
        end
        return p;
    endfunction

    initial
    begin
        logic [7:0] inv, v;
        for (int n = 0; n < 256; n++)
        begin
            inv = '0;
            for (int m = 1; m < 256; m++)
                if (gmul(n[7:0], m[7:0]) == 8'h01) inv = m[7:0];
            v = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
            sub_tab[n] = v;
        end
    end

    // AES-128 encryption with on-the-fly key schedule; byte 0 in the top bits
    function automatic logic [127:0] cipher(input logic [127:0] key, input logic [127:0] pt);
        logic [7:0]   st [16];
        logic [7:0]   sh [16];
        logic [7:0]   rc;
        logic [127:0] rk;
        logic [31:0]  t, w0, w1, w2, w3;
        logic [7:0]   a0, a1, a2, a3, al;
        logic [127:0] res;
        rk = key;
        rc = 8'h01;
        for (int i = 0; i < 16; i++) st[i] = pt[127-8*i -: 8] ^ rk[127-8*i -: 8];
        for (int r = 1; r <= 10; r++)
        begin
            for (int i = 0; i < 16; i++)
                sh[i] = sub_tab[st[(i & 3) + 4 * (((i >> 2) + (i & 3)) & 3)]];
            if (r != 10)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    a0 = sh[4*c]; a1 = sh[4*c+1]; a2 = sh[4*c+2]; a3 = sh[4*c+3];
                    al = a0 ^ a1 ^ a2 ^ a3;
                    sh[4*c]   = a0 ^ al ^ dbl(a0 ^ a1);
                    sh[4*c+1] = a1 ^ al ^ dbl(a1 ^ a2);
                    sh[4*c+2] = a2 ^ al ^ dbl(a2 ^ a3);
                    sh[4*c+3] = a3 ^ al ^ dbl(a3 ^ a0);
                end
            end
            t  = {sub_tab[rk[23:16]] ^ rc, sub_tab[rk[15:8]], sub_tab[rk[7:0]],
                  sub_tab[rk[31:24]]};
            w0 = rk[127:96] ^ t;
            w1 = rk[95:64] ^ w0;
            w2 = rk[63:32] ^ w1;
            w3 = rk[31:0] ^ w2;
            rk = {w0, w1, w2, w3};
            rc = dbl(rc);
            for (int i = 0; i < 16; i++) st[i] = sh[i] ^ rk[127-8*i -: 8];
        end
        for (int i = 0; i < 16; i++) res[127-8*i -: 8] = st[i];
        return res;
    endfunction

    function automatic answer_t compute_response();
        answer_t      a;
        logic [127:0] key, blk, ct, pay;
        int           len;
        a = '0;
        if (req.key_number == 8'd0)
            key = BUILTIN_KEY;
        else if (req.key_number == cur_num)
            key = cur_key;
        else if (cur_num != 0 && req.key_number == cur_num - 8'd1)
            key = prev_key;
        else
        begin
            a.status = 1'b1;
            return a;
        end
        len = (req.payload_len > 17) ? 17 : int'(req.payload_len);
        key[127:80] ^= req.challenge;
        blk = {req.nonce, req.msg_counter, req.control_byte & 8'hBF, req.msg_type,
               req.sender_addr, req.dest_addr, (len >= 1) ? req.payload_first : 8'h00};
        ct = cipher(key, blk);
        a.ack_auth = ct[127:96];
        pay = {req.payload_mid, req.payload_tail};
        for (int k = 0; k < 16; k++)
            if (k + 1 < len) ct[127-8*k -: 8] ^= pay[127-8*k -: 8];
        {a.response_hi, a.response_lo} = cipher(key, ct);
        return a;
    endfunction

    assign pending = answers.size();

    always @(posedge clk or negedge rst_n)
    begin
        answer_t want;
        if (!rst_n)
        begin
            cur_key    <= '0;
            prev_key   <= '0;
            cur_num    <= '0;
            fail_count <= 0;
            answers.delete();
        end
        else
        begin
            // register shadow
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_CUR_KEY_HI:  cur_key[127:64]  <= cfg_wdata;
                    REG_CUR_KEY_LO:  cur_key[63:0]    <= cfg_wdata;
                    REG_PREV_KEY_HI: prev_key[127:64] <= cfg_wdata;
                    REG_PREV_KEY_LO: prev_key[63:0]   <= cfg_wdata;
                    REG_CUR_KEY_NUM: cur_num          <= cfg_wdata[7:0];
                    default: ;
                endcase
            end
            if (req.valid && req.ready)
                answers = {answers, compute_response()};
            // result transfer check
            if (rsp.valid && rsp.ready)
            begin
                if (answers.size() == 0)
                begin
                    $display("%0t: unexpected result %h %h %h %b", $time, rsp.response_hi,
                             rsp.response_lo, rsp.ack_auth, rsp.status);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = answers.pop_front();
                    if (want.response_hi !== rsp.response_hi || want.response_lo !== rsp.response_lo
                        || want.ack_auth !== rsp.ack_auth || want.status !== rsp.status)
                    begin
                        $display("%0t: mismatch exp %h %h %h %b got %h %h %h %b", $time,
                                 want.response_hi, want.response_lo, want.ack_auth, want.status,
                                 rsp.response_hi, rsp.response_lo, rsp.ack_auth, rsp.status);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
    import acr_pkg::*;

    localparam int LATENCY   = 20;
    localparam int IDLE_STOP = 20000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_addr;
    logic [63:0] cfg_wdata;
    int          fail_count;
    int          pending;
    int          quiet_cycles;
    logic [7:0]  key_num_now;

    acr_req_if req ();
    acr_rsp_if rsp ();

    aes_challenge_response_gen_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .rsp       (rsp)
    );

    acr_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .req        (req),
        .rsp        (rsp),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Receiver side: random stalls
    initial
    begin
        int g;
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            g = gap_len();
            if (g == 0)
            begin
                rsp.ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                rsp.ready <= 1'b0;
                repeat (g) @(posedge clk);
            end
        end
    end

    // Hang detector
    always @(posedge clk)
    begin
        if (!rst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_STOP)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Write enable stays high across back-to-back writes; the caller drops it
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= data;
        @(posedge clk);
    endtask

    task automatic drain();
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic load_keys(input logic [127:0] cur, input logic [127:0] prev,
                             input logic [7:0] num);
        drain();
        write_reg(REG_CUR_KEY_HI, cur[127:64]);
        write_reg(REG_CUR_KEY_LO, cur[63:0]);
        write_reg(REG_PREV_KEY_HI, prev[127:64]);
        write_reg(REG_PREV_KEY_LO, prev[63:0]);
        write_reg(REG_CUR_KEY_NUM, {56'd0, num});
        cfg_we <= 1'b0;
        key_num_now = num;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Present one request and hold it until transferred
    task automatic send_request(input logic [47:0] chal, input logic [7:0] kn,
                                input logic [47:0] nc, input logic [7:0] ctr,
                                input logic [7:0] ctl, input logic [7:0] mt,
                                input logic [23:0] sa, input logic [23:0] da,
                                input logic [4:0] len, input logic [7:0] p0,
                                input logic [63:0] pm, input logic [63:0] pt);
        int g;
        g = gap_len();
        if (g != 0)
        begin
            req.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        req.valid         <= 1'b1;
        req.challenge     <= chal;
        req.key_number    <= kn;
        req.nonce         <= nc;
        req.msg_counter   <= ctr;
        req.control_byte  <= ctl;
        req.msg_type      <= mt;
        req.sender_addr   <= sa;
        req.dest_addr     <= da;
        req.payload_len   <= len;
        req.payload_first <= p0;
        req.payload_mid   <= pm;
        req.payload_tail  <= pt;
        @(posedge clk);
        while (!req.ready) @(posedge clk);
    endtask

    task automatic random_request(input int n);
        logic [7:0] kn;
        logic [4:0] len;
        int         pick;
        int         r;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 3) kn = 8'd0;
            else if (pick < 6) kn = key_num_now;
            else if (pick < 8) kn = key_num_now - 8'd1;
            else kn = 8'($urandom_range(0, 255));
            r = $urandom_range(0, 9);
            len = (r < 7) ? 5'($urandom_range(0, 17)) : 5'($urandom_range(0, 31));
            send_request(48'(rand64()), kn, 48'(rand64()), 8'($urandom()), 8'($urandom()),
                         8'($urandom()), 24'($urandom()), 24'($urandom()), len,
                         8'($urandom()), rand64(), rand64());
        end
        req.valid <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        req.valid         = 1'b0;
        req.challenge     = '0;
        req.key_number    = '0;
        req.nonce         = '0;
        req.msg_counter   = '0;
        req.control_byte  = '0;
        req.msg_type      = '0;
        req.sender_addr   = '0;
        req.dest_addr     = '0;
        req.payload_len   = '0;
        req.payload_first = '0;
        req.payload_mid   = '0;
        req.payload_tail  = '0;
        cfg_we            = 1'b0;
        cfg_addr          = '0;
        cfg_wdata         = '0;
        key_num_now       = 8'd0;
        rst_n             = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset keys, default key, no-key, field extremes, lengths
        send_request('0, 8'd0, '0, 8'd0, 8'd0, 8'd0, '0, '0, 5'd0, 8'd0, '0, '0);
        send_request('1, 8'd0, '1, 8'hFF, 8'hFF, 8'hFF, '1, '1, 5'd31, 8'hFF, '1, '1);
        send_request('1, 8'd1, '1, 8'hFF, 8'hFF, 8'hFF, '1, '1, 5'd17, 8'hFF, '1, '1);
        send_request('0, 8'd255, '0, 8'd0, 8'h40, 8'd0, '0, '0, 5'd1, 8'hA5, '1, '1);
        req.valid <= 1'b0;
        load_keys(128'h000102030405060708090A0B0C0D0E0F,
                  128'hFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFF, 8'd1);
        for (int l = 0; l <= 18; l += 2)
            send_request(48'hA5A5_5A5A_F00F, (l % 4 == 0) ? 8'd1 : 8'd0,
                         48'h0123_4567_89AB, 8'(l), 8'hC0, 8'h11, 24'h123456, 24'hFEDCBA,
                         5'(l), 8'h3C, 64'h8877665544332211, 64'hFFEEDDCCBBAA9988);
        send_request('1, 8'd0, '0, 8'd1, 8'h40, 8'd2, '0, '1, 5'd2, 8'd0, '1, '0);
        send_request('0, 8'd2, '0, 8'd0, 8'd0, 8'd0, '0, '0, 5'd0, 8'd0, '0, '0);
        req.valid <= 1'b0;
        load_keys('1, '0, 8'd255);
        send_request('0, 8'd255, '1, 8'd0, 8'd0, 8'd0, '0, '0, 5'd16, 8'd7, '1, '1);
        send_request('1, 8'd254, '0, 8'd0, 8'd0, 8'd0, '1, '0, 5'd3, 8'd7, '1, '1);
        send_request('0, 8'd253, '0, 8'd0, 8'd0, 8'd0, '0, '0, 5'd0, 8'd0, '0, '0);
        req.valid <= 1'b0;

        // Random phases across key settings; each load waits for an empty pipe
        load_keys(128'h0, 128'h0, 8'd0);
        random_request(150);
        for (int ph = 0; ph < 8; ph++)
        begin
            load_keys({rand64(), rand64()}, {rand64(), rand64()},
                      (ph == 3) ? 8'd1 : 8'($urandom_range(1, 255)));
            random_request(200);
        end

        drain();
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
